### design/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Used by pli_table, pli_div and piecewise_linear_interpolator_top.
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;
    localparam int POINT_W    = 7;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } t_request;

    typedef struct packed {
        logic signed [DATA_W-1:0] height;
        logic [1:0]               status;
        logic [POINT_W-1:0]       point_count;
    } t_result;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_tbl_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_CHK,
        S_Q_FIRST,
        S_Q_LAST,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SEG_A,
        S_SEG_B,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESP
    } t_state;

endpackage

### design/pli_table.sv
// Breakpoint table: x and y memories with one write and one registered read port.
// Depends on pli_pkg.
module pli_table (
    input  logic                             i_clk,
    input  pli_pkg::t_tbl_wr                 i_wr,
    input  logic [pli_pkg::IDX_W-1:0]        i_rd_addr,
    output logic signed [pli_pkg::DATA_W-1:0] o_rd_x,
    output logic signed [pli_pkg::DATA_W-1:0] o_rd_y
);
    import pli_pkg::*;

    logic signed [DATA_W-1:0] mem_x [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_y [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_x[i_wr.addr] <= i_wr.x;
            mem_y[i_wr.addr] <= i_wr.y;
        end
        o_rd_x <= mem_x[i_rd_addr];
        o_rd_y <= mem_y[i_rd_addr];
    end

endmodule

### design/pli_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit in DATA_W bits.
// Depends on pli_pkg.
module pli_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [2*pli_pkg::DATA_W-1:0]   i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [pli_pkg::DATA_W-1:0]     o_quotient
);
    import pli_pkg::*;

    logic                 r_run, n_run;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]    r_dq, n_dq;
    logic [DATA_W-1:0]    r_div, n_div;
    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    trial;

    always_comb begin
        shifted = {r_rem, r_dq[DATA_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div};
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_div   = r_div;
        if (i_start) begin
            // high half is below the divisor, so it seeds the remainder
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = i_dividend[2*DATA_W-1:DATA_W];
            n_dq  = i_dividend[DATA_W-1:0];
            n_div = i_divisor;
        end else if (r_run) begin
            if (trial[DATA_W+1]) begin
                n_rem = shifted[DATA_W-1:0];
                n_dq  = {r_dq[DATA_W-2:0], 1'b0};
            end else begin
                n_rem = trial[DATA_W-1:0];
                n_dq  = {r_dq[DATA_W-2:0], 1'b1};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

### design/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator: sequencer, breakpoint table and divider.
// Depends on pli_pkg, pli_table and pli_div.
//
// Usage: drive i_request and raise start while busy is low; the request is
// taken at that edge and busy stays high until the result has been shown.
// Each request gives exactly one result on o_result, marked by o_valid for
// one cycle; the receiver must take it then, it cannot hold the block off.
// Actions: clear empties the table, append adds a breakpoint (refused with
// a status code when the table is full or x does not rise), query returns
// the height at x, clamped to the end heights outside the table.
// Steps from the accepting edge to the o_valid cycle:
//   clear, append on a full or empty table, query on an empty table: direct
//   other appends: one table read to check ordering
//   query: one or two end checks; a query inside the table then runs a
//   binary search over the single table read port, one multiply and the
//   bit-serial divider.
// A new request is taken in the cycle after o_valid. Reset clears the point
// count and the sequencer; the table contents are not cleared and are only
// read below the point count.
module piecewise_linear_interpolator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pli_pkg::t_request i_request,
    output logic              busy,
    output logic              o_valid,
    output pli_pkg::t_result  o_result
);
    import pli_pkg::*;

    t_state                   r_state, n_state;
    t_request                 r_req, n_req;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_lo, n_lo;
    logic [IDX_W-1:0]         r_hi, n_hi;
    logic [IDX_W-1:0]         r_mid, n_mid;
    logic signed [DATA_W-1:0] r_x0, n_x0;
    logic signed [DATA_W-1:0] r_y0, n_y0;
    logic [DATA_W-1:0]        r_dxs, n_dxs;
    logic [DATA_W-1:0]        r_dxq, n_dxq;
    logic [DATA_W-1:0]        r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [2*DATA_W-1:0]      r_prod, n_prod;
    logic signed [DATA_W-1:0] r_height, n_height;
    logic [1:0]               r_status, n_status;

    logic                     accept;
    logic                     full;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         mid_calc;
    logic signed [DATA_W-1:0] rd_x, rd_y;
    logic [IDX_W-1:0]         rd_addr;
    t_tbl_wr                  wr;
    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        quotient;
    logic signed [DATA_W:0]   dx_s, dx_q, dy;
    logic [DATA_W:0]          dy_abs;
    logic signed [DATA_W:0]   y_sum;

    assign accept   = start && (r_state == S_IDLE);
    assign full     = (r_count >= CNT_W'(MAX_POINTS));
    assign last_idx = IDX_W'(r_count - 1'b1);
    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);

    pli_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dxq),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_request.action)
                        ACT_APPEND: n_state = (full || r_count == '0) ? S_RESP : S_APP_CHK;
                        ACT_QUERY:  n_state = (r_count == '0) ? S_RESP : S_Q_FIRST;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_APP_CHK:  n_state = S_RESP;
            S_Q_FIRST:  n_state = (r_req.x_value <= rd_x) ? S_RESP : S_Q_LAST;
            S_Q_LAST:   n_state = (r_req.x_value >= rd_x) ? S_RESP : S_SRCH_RD;
            S_SRCH_RD:  n_state = (r_lo < r_hi) ? S_SRCH_CMP : S_SEG_A;
            S_SRCH_CMP: n_state = S_SRCH_RD;
            S_SEG_A:    n_state = S_SEG_B;
            S_SEG_B:    n_state = S_MUL;
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: n_state = div_done ? S_RESP : S_DIV_WAIT;
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs: table port, divider start, handshake
    always_comb begin
        rd_addr   = '0;
        wr.en     = 1'b0;
        wr.addr   = IDX_W'(r_count);
        wr.x      = r_req.x_value;
        wr.y      = r_req.y_value;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = (i_request.action == ACT_APPEND) ? last_idx : '0;
                wr.x    = i_request.x_value;
                wr.y    = i_request.y_value;
                wr.en   = accept && (i_request.action == ACT_APPEND) && (r_count == '0);
            end
            S_APP_CHK:  wr.en = !(r_req.x_value <= rd_x);
            S_Q_FIRST:  rd_addr = last_idx;
            S_SRCH_RD:  rd_addr = (r_lo < r_hi) ? mid_calc : (r_lo - 1'b1);
            S_SEG_A:    rd_addr = r_lo;
            S_DIV_GO:   div_start = 1'b1;
            default:    rd_addr = '0;
        endcase
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_valid              = (r_state == S_RESP);
    assign o_result.height      = r_height;
    assign o_result.status      = r_status;
    assign o_result.point_count = POINT_W'(r_count);

    // datapath
    always_comb begin
        n_req    = r_req;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_dxs    = r_dxs;
        n_dxq    = r_dxq;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_height = r_height;
        n_status = r_status;
        dx_s     = {r_req.x_value[DATA_W-1], r_req.x_value} - {r_x0[DATA_W-1], r_x0};
        dx_q     = {rd_x[DATA_W-1], rd_x} - {r_x0[DATA_W-1], r_x0};
        dy       = {rd_y[DATA_W-1], rd_y} - {r_y0[DATA_W-1], r_y0};
        dy_abs   = dy[DATA_W] ? (DATA_W+1)'(-dy) : dy;
        y_sum    = r_neg ? ({r_y0[DATA_W-1], r_y0} - {1'b0, quotient})
                         : ({r_y0[DATA_W-1], r_y0} + {1'b0, quotient});
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_request;
                    n_height = '0;
                    n_status = STAT_OK;
                    case (i_request.action)
                        ACT_CLEAR:  n_count = '0;
                        ACT_APPEND: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else if (r_count == '0) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end
                        end
                        default: n_status = STAT_OK;
                    endcase
                end
            end
            S_APP_CHK: begin
                if (r_req.x_value <= rd_x) begin
                    n_status = STAT_ORDER;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            S_Q_FIRST: begin
                if (r_req.x_value <= rd_x) begin
                    n_height = rd_y;
                end
            end
            S_Q_LAST: begin
                n_height = rd_y;
                n_lo     = IDX_W'(1);
                n_hi     = last_idx;
            end
            S_SRCH_RD: n_mid = mid_calc;
            S_SRCH_CMP: begin
                // narrow to the first breakpoint above the query x
                if (rd_x > r_req.x_value) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
            end
            S_SEG_A: begin
                n_x0 = rd_x;
                n_y0 = rd_y;
            end
            S_SEG_B: begin
                n_dxs = dx_s[DATA_W-1:0];
                n_dxq = dx_q[DATA_W-1:0];
                n_mag = dy_abs[DATA_W-1:0];
                n_neg = dy[DATA_W];
            end
            S_MUL: n_prod = r_dxs * r_mag;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_height = y_sum[DATA_W-1:0];
                end
            end
            default: n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req    <= n_req;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_dxs    <= n_dxs;
        r_dxq    <= n_dxq;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_height <= n_height;
        r_status <= n_status;
    end

endmodule
